// ===== rtl/u16u8_pkg.sv =====
// shared types, codes and byte-forming functions for the utf-16 to utf-8 encoder
package u16u8_pkg;

  localparam int UNIT_W = 16;
  localparam int CP_W   = 21;
  localparam int BYTE_W = 8;
  localparam int QDEPTH = 2;

  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5c;
  localparam logic [BYTE_W-1:0] CH_X      = 8'h78;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DEL    = 8'h7f;

  typedef enum logic [2:0] {
    KIND_ESC,
    KIND_ASCII,
    KIND_TWO,
    KIND_THREE,
    KIND_FOUR
  } pt_kind_t;

  // one unit of work for the byte serializer
  typedef struct packed {
    logic              pre3;
    logic [UNIT_W-1:0] pre_unit;
    logic              has_pt;
    pt_kind_t          kind;
    logic [CP_W-1:0]   cp;
  } job_t;

  function automatic pt_kind_t classify(input logic [CP_W-1:0] cp);
    pt_kind_t k;
    if (cp < 21'h20 || cp == 21'(CH_BSLASH) || cp == 21'(CH_QUOTE) || cp == 21'(CH_DEL)) begin
      k = KIND_ESC;
    end else if (cp < 21'h80) begin
      k = KIND_ASCII;
    end else if (cp < 21'h800) begin
      k = KIND_TWO;
    end else if (cp < 21'h10000) begin
      k = KIND_THREE;
    end else begin
      k = KIND_FOUR;
    end
    return k;
  endfunction

  function automatic logic [1:0] pt_last(input pt_kind_t k);
    logic [1:0] n;
    case (k)
      KIND_ESC:   n = 2'd3;
      KIND_ASCII: n = 2'd0;
      KIND_TWO:   n = 2'd1;
      KIND_THREE: n = 2'd2;
      KIND_FOUR:  n = 2'd3;
      default:    n = 2'd0;
    endcase
    return n;
  endfunction

  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
    logic [BYTE_W-1:0] d;
    if (v < 4'd10) begin
      d = 8'h30 + {4'b0, v};
    end else begin
      d = 8'h57 + {4'b0, v};
    end
    return d;
  endfunction

  function automatic logic [BYTE_W-1:0] three_byte(input logic [UNIT_W-1:0] u,
                                                   input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    case (idx)
      2'd0:    b = {4'he, u[15:12]};
      2'd1:    b = {2'b10, u[11:6]};
      default: b = {2'b10, u[5:0]};
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] pt_byte(input logic [CP_W-1:0] cp,
                                                input pt_kind_t k,
                                                input logic [1:0] idx);
    logic [BYTE_W-1:0] b;
    b = '0;
    case (k)
      KIND_ESC: begin
        case (idx)
          2'd0:    b = CH_BSLASH;
          2'd1:    b = CH_X;
          2'd2:    b = hex_digit(cp[7:4]);
          default: b = hex_digit(cp[3:0]);
        endcase
      end
      KIND_ASCII: b = cp[7:0];
      KIND_TWO: begin
        if (idx == 2'd0) begin
          b = {3'b110, cp[10:6]};
        end else begin
          b = {2'b10, cp[5:0]};
        end
      end
      KIND_THREE: b = three_byte(cp[15:0], idx);
      KIND_FOUR: begin
        case (idx)
          2'd0:    b = {5'b11110, cp[20:18]};
          2'd1:    b = {2'b10, cp[17:12]};
          2'd2:    b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: b = '0;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/utf16_to_utf8_escaping_encoder_core.sv =====
// utf-16 to utf-8 encoder with escaping of control, quote, backslash and delete units
// An item is one UTF-16 code unit (s_tlast marks the final unit of a string); it turns
// into zero to seven UTF-8 or escape bytes on the output, each a single item, with m_tlast
// on the last byte caused by that unit. A high surrogate that is not final is held and
// gives no bytes until the next unit arrives. Input items are taken every cycle while the
// two-entry job queue has room; the byte serializer emits one byte per cycle while a job
// is queued and the output is not stalled. A unit gives three bytes for a lone surrogate,
// four for a pair or an escape, seven for an unpaired held surrogate followed by an escape;
// the serializer sets the sustained rate; jobs pass the queue, then the output register.
module utf16_to_utf8_escaping_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // code_unit
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte
  output logic        m_tlast
);
  import u16u8_pkg::*;

  job_t push_job;
  job_t head_job;
  logic push;
  logic pop;
  logic q_not_empty;
  logic q_not_full;

  u16u8_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_unit  (s_tdata),
    .in_last  (s_tlast),
    .room     (q_not_full),
    .push     (push),
    .job      (push_job)
  );

  u16u8_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_job    (push_job),
    .pop       (pop),
    .rd_job    (head_job),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  u16u8_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head_job),
    .head_valid (q_not_empty),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_byte   (m_tdata),
    .out_last   (m_tlast)
  );

endmodule

// ===== rtl/u16u8_front.sv =====
// front end: accepts code units, pairs surrogates and classifies the item into a job
module u16u8_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [u16u8_pkg::UNIT_W-1:0] in_unit,
  input  logic                     in_last,
  input  logic                     room,
  output logic                     push,
  output u16u8_pkg::job_t          job
);
  import u16u8_pkg::*;

  logic [UNIT_W-1:0] held_high;
  logic              held_valid;
  logic              is_high;
  logic              is_low;
  logic              accept;

  assign is_high  = (in_unit[15:10] == 6'b110110);
  assign is_low   = (in_unit[15:10] == 6'b110111);
  assign in_ready = room;
  assign accept   = in_valid && in_ready;

  always_comb begin
    job          = '0;
    job.pre_unit = held_high;
    if (held_valid && is_low) begin
      job.has_pt = 1'b1;
      job.kind   = KIND_FOUR;
      job.cp     = 21'h10000 + {1'b0, held_high[9:0], in_unit[9:0]};
    end else begin
      job.pre3 = held_valid;
      if (is_high && !in_last) begin
        job.has_pt = 1'b0;
      end else begin
        job.has_pt = 1'b1;
        job.cp     = {5'b0, in_unit};
        job.kind   = classify({5'b0, in_unit});
      end
    end
  end

  assign push = accept && (job.pre3 || job.has_pt);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= '0;
    end else if (accept) begin
      if (is_high && !in_last && !(held_valid && is_low)) begin
        held_valid <= 1'b1;
        held_high  <= in_unit;
      end else begin
        held_valid <= 1'b0;
        held_high  <= '0;
      end
    end
  end

endmodule

// ===== rtl/u16u8_queue.sv =====
// two-entry job queue between front end and byte serializer
module u16u8_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  u16u8_pkg::job_t wr_job,
  input  logic            pop,
  output u16u8_pkg::job_t rd_job,
  output logic            not_empty,
  output logic            not_full
);
  import u16u8_pkg::*;

  job_t       mem [QDEPTH];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign not_empty = (count != 2'd0);
  assign not_full  = (count != 2'(QDEPTH));
  assign rd_job    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ===== rtl/u16u8_back.sv =====
// back end: walks the head job into the output register one byte per cycle while not stalled
module u16u8_back (
  input  logic                         clk,
  input  logic                         rst,
  input  u16u8_pkg::job_t              head,
  input  logic                         head_valid,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [u16u8_pkg::BYTE_W-1:0] out_byte,
  output logic                         out_last
);
  import u16u8_pkg::*;

  logic              seg_pt;
  logic [1:0]        idx;
  logic              in_pt;
  logic              done_job;
  logic              step;
  logic [BYTE_W-1:0] cur_byte;

  assign in_pt    = seg_pt || !head.pre3;
  assign cur_byte = in_pt ? pt_byte(head.cp, head.kind, idx) : three_byte(head.pre_unit, idx);
  assign done_job = in_pt ? (idx == pt_last(head.kind)) : (idx == 2'd2 && !head.has_pt);
  assign step     = head_valid && (!out_valid || out_ready);
  assign pop      = step && done_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_byte  <= '0;
      out_last  <= 1'b0;
      seg_pt    <= 1'b0;
      idx       <= '0;
    end else if (step) begin
      out_valid <= 1'b1;
      out_byte  <= cur_byte;
      out_last  <= done_job;
      if (done_job) begin
        seg_pt <= 1'b0;
        idx    <= '0;
      end else if (!in_pt && idx == 2'd2) begin
        seg_pt <= 1'b1;
        idx    <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/u16u8_checker.sv =====
// port-level checks for the encoder, bound to the top level
module u16u8_checker (
  input logic       clk,
  input logic       rst,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);
  import u16u8_pkg::*;

  logic after_bslash;

  always_ff @(posedge clk) begin
    if (rst) begin
      after_bslash <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      after_bslash <= (m_tdata == CH_BSLASH);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_reset_clean: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("output busy or input blocked after reset");

  a_escape_x: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && after_bslash |-> m_tdata == CH_X)
    else $error("backslash not followed by x");

  a_lead_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata == CH_BSLASH || m_tdata[7:3] == 5'b11110) |-> !m_tlast)
    else $error("escape or four-byte lead marked as last byte");

endmodule

bind utf16_to_utf8_escaping_encoder_core u16u8_checker u_chk (.*);
